>>> hdl/mrfd_pkg.sv
// ----------------------------------------------------------------------------
// mrfd_pkg
// Shared constants, types and helper functions of the meter radio row decoder.
// ----------------------------------------------------------------------------
package mrfd_pkg;

    localparam int FRAME_BYTES = 9;
    localparam int ADDR_W      = $clog2(FRAME_BYTES);
    localparam int POS_W       = 4;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_LEN  = 3'd1;
    localparam logic [2:0] ST_BAD_SYNC = 3'd2;
    localparam logic [2:0] ST_BAD_XOR  = 3'd3;
    localparam logic [2:0] ST_BAD_SUM  = 3'd4;

    localparam logic [6:0] LEN_SHORT_A = 7'd55;
    localparam logic [6:0] LEN_SHORT_B = 7'd56;
    localparam logic [6:0] LEN_LONG_A  = 7'd71;
    localparam logic [6:0] LEN_LONG_B  = 7'd72;

    localparam logic [POS_W-1:0] SHORT_LAST_POS = 4'd6;
    localparam logic [POS_W-1:0] LONG_LAST_POS  = 4'd8;
    localparam logic [POS_W-1:0] SHORT_XOR_LAST = 4'd5;
    localparam logic [POS_W-1:0] LONG_XOR_LAST  = 4'd7;

    localparam logic [ADDR_W-1:0] IDX_FIRST     = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] IDX_SHORT_TOP = ADDR_W'(4);
    localparam logic [ADDR_W-1:0] IDX_LONG_TOP  = ADDR_W'(6);
    localparam logic [ADDR_W-1:0] IDX_SHORT_CMP = ADDR_W'(6);
    localparam logic [ADDR_W-1:0] IDX_LONG_CMP  = ADDR_W'(8);

    localparam logic [7:0]  SYNC_RAW   = ~8'hFA;
    localparam logic [7:0]  XOR_GOOD   = 8'hFF;
    localparam logic [15:0] MASK_INIT  = 16'h0001;

    localparam logic [15:0] TAP_TABLE [0:14] = '{
        16'h4880, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h2080, 16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'h4000
    };

    typedef struct packed {
        logic collect;
        logic rd_first;
        logic cap_first;
        logic rd_top;
        logic load;
        logic step;
        logic rd_next;
        logic rd_cmp;
        logic cap_cmp;
        logic emit;
    } mrfd_cmd_t;

    typedef struct packed {
        logic row_end;
        logic early_fail;
        logic last_bit;
        logic first_byte;
        logic out_free;
    } mrfd_stat_t;

    function automatic logic [15:0] advance_mask(input logic [15:0] m);
        logic [15:0] n;
        n = m >> 1;
        for (int k = 0; k < 15; k++)
        begin
            if (m[k])
            begin
                n = n ^ TAP_TABLE[k];
            end
        end
        return n;
    endfunction

    function automatic logic [7:0] mirror8(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++)
        begin
            r[7-k] = v[k];
        end
        return r;
    endfunction

endpackage

>>> hdl/mrfd_ram.sv
// ----------------------------------------------------------------------------
// mrfd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mrfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 9
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/mrfd_ctrl.sv
// ----------------------------------------------------------------------------
// mrfd_ctrl
// Sequencer: collect the row, walk the stored bytes for the checksum, emit.
// ----------------------------------------------------------------------------
module mrfd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mrfd_pkg::mrfd_stat_t stat,
    output mrfd_pkg::mrfd_cmd_t  cmd
);

    localparam logic [3:0] S_COLLECT = 4'd0;
    localparam logic [3:0] S_CHECK   = 4'd1;
    localparam logic [3:0] S_FIRST   = 4'd2;
    localparam logic [3:0] S_RDTOP   = 4'd3;
    localparam logic [3:0] S_LOAD    = 4'd4;
    localparam logic [3:0] S_SHIFT   = 4'd5;
    localparam logic [3:0] S_RDCMP   = 4'd6;
    localparam logic [3:0] S_CMP     = 4'd7;
    localparam logic [3:0] S_EMIT    = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_COLLECT:
            begin
                cmd.collect = 1'b1;
                if (stat.row_end)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.early_fail)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.rd_first = 1'b1;
                    state_next   = S_FIRST;
                end
            end
            S_FIRST:
            begin
                cmd.cap_first = 1'b1;
                state_next    = S_RDTOP;
            end
            S_RDTOP:
            begin
                cmd.rd_top = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                cmd.step = 1'b1;
                if (stat.last_bit)
                begin
                    if (stat.first_byte)
                    begin
                        state_next = S_RDCMP;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                        state_next  = S_LOAD;
                    end
                end
            end
            S_RDCMP:
            begin
                cmd.rd_cmp = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.cap_cmp = 1'b1;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_COLLECT;
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

endmodule

>>> hdl/mrfd_dp.sv
// ----------------------------------------------------------------------------
// mrfd_dp
// Datapath: row store, running XOR, byte decode, serial checksum, result.
// ----------------------------------------------------------------------------
module mrfd_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mrfd_pkg::mrfd_cmd_t  cmd,
    output mrfd_pkg::mrfd_stat_t stat,
    input  logic                 in_valid,
    input  logic [7:0]           raw_byte,
    input  logic                 last_byte,
    input  logic [6:0]           row_bits,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [2:0]           status,
    output logic                 long_packet,
    output logic [7:0]           sensor_id,
    output logic [3:0]           channel,
    output logic [18:0]          pulse_interval,
    output logic [33:0]          impulse_count,
    output logic                 batt_good
);

    localparam int AW = mrfd_pkg::ADDR_W;
    localparam int PW = mrfd_pkg::POS_W;

    logic          accept;
    logic [PW-1:0] pos_reg;
    logic [7:0]    x5_reg;
    logic [7:0]    x7_reg;
    logic          sync_ok_reg;
    logic [6:0]    bits_reg;
    logic [2:0]    status_reg;
    logic          islong_reg;
    logic [AW-1:0] idx_reg;
    logic [7:0]    byte_reg;
    logic [2:0]    bit_reg;
    logic [15:0]   mask_reg;
    logic [15:0]   sum_reg;
    logic          cmp_ok_reg;
    logic [47:0]   data_reg;
    logic          out_valid_reg;
    logic [2:0]    status_out_reg;
    logic          long_out_reg;
    logic [7:0]    id_out_reg;
    logic [3:0]    chan_out_reg;
    logic [18:0]   gap_out_reg;
    logic [33:0]   count_out_reg;
    logic          batt_out_reg;

    logic          wr_en;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic          len_short;
    logic          len_long;
    logic          len_ok;
    logic          xor_ok;
    logic [2:0]    early_code;
    logic          row_long;
    logic [AW-1:0] last_idx;
    logic [2:0]    part_bits;
    logic [7:0]    part_mask;
    logic [7:0]    inv_byte;
    logic [7:0]    pb;
    logic [15:0]   mask_step;
    logic [2:0]    final_code;

    assign accept = in_valid && cmd.collect;
    assign wr_en  = accept && ({1'b0, pos_reg} < (PW+1)'(mrfd_pkg::FRAME_BYTES));

    mrfd_ram #(
        .WIDTH (8),
        .DEPTH (mrfd_pkg::FRAME_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (AW'(pos_reg)),
        .wr_data (raw_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign len_short = (row_bits == mrfd_pkg::LEN_SHORT_A) ||
                       (row_bits == mrfd_pkg::LEN_SHORT_B);
    assign len_long  = (row_bits == mrfd_pkg::LEN_LONG_A) ||
                       (row_bits == mrfd_pkg::LEN_LONG_B);
    assign len_ok    = (len_short && pos_reg == mrfd_pkg::SHORT_LAST_POS) ||
                       (len_long  && pos_reg == mrfd_pkg::LONG_LAST_POS);
    assign xor_ok    = len_long ? (x7_reg == mrfd_pkg::XOR_GOOD)
                                : (x5_reg == mrfd_pkg::XOR_GOOD);

    always_comb
    begin
        if (!len_ok)
        begin
            early_code = mrfd_pkg::ST_BAD_LEN;
        end
        else if (!sync_ok_reg)
        begin
            early_code = mrfd_pkg::ST_BAD_SYNC;
        end
        else if (!xor_ok)
        begin
            early_code = mrfd_pkg::ST_BAD_XOR;
        end
        else
        begin
            early_code = mrfd_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            x5_reg      <= '0;
            x7_reg      <= '0;
            sync_ok_reg <= 1'b0;
            status_reg  <= mrfd_pkg::ST_OK;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                pos_reg    <= '0;
                status_reg <= early_code;
            end
            else if (pos_reg != mrfd_pkg::POS_MAX)
            begin
                pos_reg <= pos_reg + 1'b1;
            end
            if (pos_reg == '0)
            begin
                x5_reg      <= '0;
                x7_reg      <= '0;
                sync_ok_reg <= (raw_byte == mrfd_pkg::SYNC_RAW);
            end
            else
            begin
                if (pos_reg <= mrfd_pkg::SHORT_XOR_LAST)
                begin
                    x5_reg <= x5_reg ^ raw_byte;
                end
                if (pos_reg <= mrfd_pkg::LONG_XOR_LAST)
                begin
                    x7_reg <= x7_reg ^ raw_byte;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_byte)
        begin
            bits_reg <= row_bits;
        end
    end

    // byte decode: invert, clear unused tail bits, mirror; beyond the row reads zero
    assign row_long  = (bits_reg >= mrfd_pkg::LEN_LONG_A);
    assign last_idx  = row_long ? mrfd_pkg::IDX_LONG_CMP : mrfd_pkg::IDX_SHORT_CMP;
    assign part_bits = bits_reg[2:0];
    assign part_mask = (part_bits == 3'd0) ? 8'hFF
                                           : 8'(8'hFF << (4'd8 - {1'b0, part_bits}));
    assign inv_byte  = ~rd_data;

    always_comb
    begin
        if (idx_reg > last_idx)
        begin
            pb = 8'h00;
        end
        else if (idx_reg == last_idx)
        begin
            pb = mrfd_pkg::mirror8(inv_byte & part_mask);
        end
        else
        begin
            pb = mrfd_pkg::mirror8(inv_byte);
        end
    end

    assign rd_en = cmd.rd_first || cmd.rd_top || cmd.rd_next || cmd.rd_cmp;

    always_comb
    begin
        if (cmd.rd_first)
        begin
            rd_addr = mrfd_pkg::IDX_FIRST;
        end
        else if (cmd.rd_top)
        begin
            rd_addr = islong_reg ? mrfd_pkg::IDX_LONG_TOP : mrfd_pkg::IDX_SHORT_TOP;
        end
        else if (cmd.rd_cmp)
        begin
            rd_addr = islong_reg ? mrfd_pkg::IDX_LONG_CMP : mrfd_pkg::IDX_SHORT_CMP;
        end
        else
        begin
            rd_addr = idx_reg - 1'b1;
        end
    end

    assign mask_step = mrfd_pkg::advance_mask(mask_reg);

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            idx_reg <= rd_addr;
        end
        if (cmd.cap_first)
        begin
            islong_reg <= pb[0];
            mask_reg   <= mrfd_pkg::MASK_INIT;
            sum_reg    <= '0;
        end
        if (cmd.load)
        begin
            byte_reg <= pb;
            bit_reg  <= 3'd7;
            data_reg <= {data_reg[39:0], pb};
        end
        if (cmd.step)
        begin
            mask_reg <= mask_step;
            bit_reg  <= bit_reg - 1'b1;
            if (byte_reg[bit_reg])
            begin
                sum_reg <= sum_reg ^ mask_step;
            end
        end
        if (cmd.cap_cmp)
        begin
            cmp_ok_reg <= (sum_reg[15:8] == pb);
        end
    end

    assign final_code = (status_reg != mrfd_pkg::ST_OK) ? status_reg :
                        (cmp_ok_reg ? mrfd_pkg::ST_OK : mrfd_pkg::ST_BAD_SUM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_out_reg <= final_code;
            long_out_reg   <= 1'b0;
            id_out_reg     <= '0;
            chan_out_reg   <= '0;
            gap_out_reg    <= '0;
            count_out_reg  <= '0;
            batt_out_reg   <= 1'b0;
            if (final_code == mrfd_pkg::ST_OK)
            begin
                long_out_reg <= islong_reg;
                id_out_reg   <= {data_reg[11:8], data_reg[7:4]};
                chan_out_reg <= {1'b0, data_reg[3:1]} + 4'd1;
                if (islong_reg)
                begin
                    count_out_reg <= {data_reg[45:40], data_reg[39:16], data_reg[15:12]};
                    batt_out_reg  <= ~data_reg[46];
                end
                else
                begin
                    gap_out_reg <= {data_reg[30:24], data_reg[23:16], data_reg[15:12]};
                end
            end
        end
    end

    assign stat.row_end    = accept && last_byte;
    assign stat.early_fail = (status_reg != mrfd_pkg::ST_OK);
    assign stat.last_bit   = (bit_reg == 3'd0);
    assign stat.first_byte = (idx_reg == mrfd_pkg::IDX_FIRST);
    assign stat.out_free   = !out_valid_reg || !out_stall;

    assign out_valid      = out_valid_reg;
    assign status         = status_out_reg;
    assign long_packet    = long_out_reg;
    assign sensor_id      = id_out_reg;
    assign channel        = chan_out_reg;
    assign pulse_interval = gap_out_reg;
    assign impulse_count  = count_out_reg;
    assign batt_good      = batt_out_reg;

endmodule

>>> hdl/meter_radio_frame_decoder.sv
// ----------------------------------------------------------------------------
// meter_radio_frame_decoder
// Decodes one received energy meter radio row: length, sync, XOR and
// checksum checks, then sensor ID, channel and impulse interval or count.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  input   | in        | in_valid / in_stall  | raw_byte, last_byte, row_bits
//  output  | out       | out_valid / out_stall| status, long_packet, sensor_id,
//          |           |                      | channel, pulse_interval,
//          |           |                      | impulse_count, batt_good
//
//  A non-last beat is taken as soon as it is valid. After the last beat the
//  input stalls for a checksum walk of one load plus eight shifts per byte;
//  a long row walks more bytes, and one that fails length, sync or XOR skips it.
//  Output back-pressure adds to this; a held result waits in the output
//  register while the next row is taken in.
//  Reset is asynchronous, active low, and clears control state only.
// ----------------------------------------------------------------------------
module meter_radio_frame_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  raw_byte,
    input  logic        last_byte,
    input  logic [6:0]  row_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic        long_packet,
    output logic [7:0]  sensor_id,
    output logic [3:0]  channel,
    output logic [18:0] pulse_interval,
    output logic [33:0] impulse_count,
    output logic        batt_good
);

    mrfd_pkg::mrfd_cmd_t  cmd;
    mrfd_pkg::mrfd_stat_t stat;

    mrfd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    mrfd_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_valid       (in_valid),
        .raw_byte       (raw_byte),
        .last_byte      (last_byte),
        .row_bits       (row_bits),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .status         (status),
        .long_packet    (long_packet),
        .sensor_id      (sensor_id),
        .channel        (channel),
        .pulse_interval (pulse_interval),
        .impulse_count  (impulse_count),
        .batt_good      (batt_good)
    );

    assign in_stall = !cmd.collect;

endmodule

>>> hdl/mrfd_checker.sv
// ----------------------------------------------------------------------------
// mrfd_checker
// Port-level checks of the row decoder, bound to the top level.
// ----------------------------------------------------------------------------
module mrfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        last_byte,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic        long_packet,
    input logic [7:0]  sensor_id,
    input logic [3:0]  channel,
    input logic [18:0] pulse_interval,
    input logic [33:0] impulse_count,
    input logic        batt_good
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(sensor_id)
            && $stable(impulse_count) && $stable(pulse_interval))
        else $error("stalled result beat changed");

    a_stall_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_byte |=> in_stall)
        else $error("input not held off while the row is decoded");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != mrfd_pkg::ST_OK |-> !long_packet && sensor_id == 8'd0
            && channel == 4'd0 && pulse_interval == 19'd0 && impulse_count == 34'd0
            && !batt_good)
        else $error("failed row carries non-zero fields");

    a_short_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == mrfd_pkg::ST_OK && !long_packet |->
            impulse_count == 34'd0 && !batt_good && channel != 4'd0)
        else $error("short packet carries long packet fields");

endmodule

bind meter_radio_frame_decoder mrfd_checker u_mrfd_checker (.*);
